// ===== sv/gabc_pkg.sv =====
package gabc_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned TIME_W = 31;
    localparam int unsigned GAP_W = 16;
    localparam int unsigned IN_DATA_W = 64;
    localparam int unsigned OUT_DATA_W = 32;
    localparam logic [GAP_W-1:0] BLINK_GAP_RESET = 16'd275;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [COORD_W-1:0]   wr_y;
        logic [COORD_W-1:0]   wr_x;
    } t_ring_ctl;

endpackage

// ===== sv/gabc_ring.sv =====
module gabc_ring #(
    parameter int unsigned WINDOW = 20,
    parameter int unsigned AW = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gabc_pkg::t_ring_ctl         i_ctl,
    input  logic [AW-1:0]               i_addr,
    output logic [gabc_pkg::COORD_W-1:0] o_old_x,
    output logic [gabc_pkg::COORD_W-1:0] o_old_y
);
    import gabc_pkg::*;

    logic [2*COORD_W-1:0] r_mem [WINDOW];
    logic [2*COORD_W-1:0] r_q;
    logic                 r_q_vld;
    logic [WINDOW-1:0]    r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= {i_ctl.wr_y, i_ctl.wr_x};
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_addr];
        end
    end

    // entries never written read back as zero, matching the cleared ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_q_vld <= r_valid[i_addr];
            end
        end
    end

    assign o_old_x = r_q_vld ? r_q[COORD_W-1:0] : '0;
    assign o_old_y = r_q_vld ? r_q[2*COORD_W-1:COORD_W] : '0;

endmodule

// ===== sv/gabc_div.sv =====
module gabc_div #(
    parameter int unsigned WINDOW = 20,
    parameter int unsigned SUM_W = 22
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic signed [SUM_W-1:0]      i_sum,
    output logic [gabc_pkg::COORD_W-1:0] o_quot
);
    import gabc_pkg::*;

    // divide by WINDOW as multiply by a rounded-up reciprocal, exact for |sum| < 2^NB
    localparam int unsigned NB = SUM_W - 1;
    localparam int unsigned CLW = $clog2(WINDOW);
    localparam int unsigned SH = NB + CLW;
    localparam int unsigned MW = NB + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [NB-1:0]    mag;
    logic [NB+MW-1:0] r_prod;
    logic             r_neg;
    logic [NB+MW-1:0] quot_mag;

    assign mag = i_sum[SUM_W-1] ? NB'(-i_sum) : NB'(i_sum);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= (NB+MW)'(mag) * (NB+MW)'(RECIP);
            r_neg  <= i_sum[SUM_W-1];
        end
    end

    assign quot_mag = r_prod >> SH;
    assign o_quot = r_neg ? COORD_W'(-quot_mag) : COORD_W'(quot_mag);

endmodule

// ===== sv/gaze_average_blink_click_unit.sv =====
// an accepted item's ring entry is read, then its result enters the output register at write-back
// a new item enters only after the read then write-back of the last item's ring entry
// the output register lets the next item enter while a result waits to be taken,
// that item then holds in its write-back cycle until the output register frees
// reset (synchronous, active low) clears the ring valid bits, running sums,
// last timestamp, first-sample flag and sets blink_gap_ms to 275; no clearing pass
module gaze_average_blink_click_unit #(
    parameter int unsigned WINDOW = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [gabc_pkg::IN_DATA_W-1:0] s_axis_tdata,  // sample_x, sample_y, sample_time_ms, pad
    input  logic        s_axis_tuser,                    // click_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [gabc_pkg::OUT_DATA_W-1:0] m_axis_tdata, // cursor_x, cursor_y
    output logic        m_axis_tuser,                    // click
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gabc_pkg::GAP_W-1:0] i_cfg_data
);
    import gabc_pkg::*;

    localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W = COORD_W + 1 + $clog2(WINDOW);

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_pos;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [TIME_W-1:0]       r_last;
    logic                    r_seen;
    logic [GAP_W-1:0]        r_gap;
    logic                    r_click;
    logic [COORD_W-1:0]      r_x_in, r_y_in;
    logic                    r_out_vld;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    r_out_click;

    logic                    accept;
    logic                    upd_go;
    logic [COORD_W-1:0]      in_x, in_y;
    logic [TIME_W-1:0]       in_time;
    logic signed [TIME_W+1:0] gap;
    logic                    click;
    t_ring_ctl               ring_ctl;
    logic [COORD_W-1:0]      old_x, old_y;
    logic [COORD_W-1:0]      avg_x, avg_y;

    assign in_x    = s_axis_tdata[COORD_W-1:0];
    assign in_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_time = s_axis_tdata[2*COORD_W+TIME_W-1:2*COORD_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    // write-back waits while the previous result is still held
    assign upd_go = (r_state == S_UPD) && (!r_out_vld || m_axis_tready);
    assign o_cfg_ready = 1'b1;

    // signed gap, a backward timestamp never passes the threshold
    assign gap = $signed({2'b00, in_time}) - $signed({2'b00, r_last});
    assign click = r_seen && ((gap > $signed({(TIME_W+2-GAP_W)'(0), r_gap})) || s_axis_tuser);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_UPD;
            S_UPD:  if (upd_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign ring_ctl.rd_en = accept;
    assign ring_ctl.wr_en = upd_go;
    assign ring_ctl.wr_x  = r_x_in;
    assign ring_ctl.wr_y  = r_y_in;

    gabc_ring #(.WINDOW(WINDOW), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .i_addr  (r_pos),
        .o_old_x (old_x),
        .o_old_y (old_y)
    );

    gabc_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_x (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_sum  (r_sum_x),
        .o_quot (avg_x)
    );

    gabc_div #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_div_y (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_sum  (r_sum_y),
        .o_quot (avg_y)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_in  <= in_x;
            r_y_in  <= in_y;
            r_click <= click;
        end
        if (upd_go) begin
            r_out_data  <= {avg_y, avg_x};
            r_out_click <= r_click;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_last    <= '0;
            r_seen    <= 1'b0;
            r_gap     <= BLINK_GAP_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_gap <= i_cfg_data;
            end
            if (accept) begin
                r_last <= in_time;
                r_seen <= 1'b1;
            end
            if (upd_go) begin
                // old entry leaves the window, new sample enters
                r_sum_x <= r_sum_x + SUM_W'($signed(r_x_in)) - SUM_W'($signed(old_x));
                r_sum_y <= r_sum_y + SUM_W'($signed(r_y_in)) - SUM_W'($signed(old_y));
                r_pos   <= (r_pos == AW'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
            end
            if (upd_go) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_click;

`ifndef SYNTHESIS
    a_accept_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD))
        else $error("accepted item did not move to update");

    a_upd_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> m_axis_tvalid)
        else $error("update cycle produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_out_vld && !m_axis_tready)
        |=> ((r_state == S_UPD) && $stable(r_out_data)))
        else $error("result register overwritten while full");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= AW'(WINDOW - 1))
        else $error("ring position out of range");
`endif

endmodule
